@@ hdl/t16x_pkg.sv @@
// Package: shared types and constants of the Thumb integer execute unit.
`default_nettype none
package t16x_pkg;
  localparam int unsigned XLEN = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [31:0] SP_RESET = 32'h2000_0000;
  localparam logic [31:0] FETCH_RESET = 32'h0000_0000;
  localparam logic [31:0] LR_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] BKPT_ENC = 16'hDE00;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FETCH = 8'd1;
  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  typedef logic [12:0][31:0] gpr_file_t;

  typedef struct packed {
    logic [31:0] next_address;
    logic        dest_valid;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic [3:0]  nzcv;
    logic        branch_taken;
    logic        breakpoint;
    logic        undefined;
  } exec_result_t;

  typedef struct packed {
    gpr_file_t   gpr;
    logic [31:0] sp;
    logic [31:0] lr;
    logic [31:0] ia;
    logic [3:0]  nzcv;
  } arch_state_t;
endpackage
`default_nettype wire

@@ hdl/t16x_channels.sv @@
// Interfaces: instruction, result and configuration channels.
`default_nettype none
interface t16x_inst_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface t16x_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_address;
  logic        dest_valid;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic [3:0]  nzcv;
  logic        branch_taken;
  logic        breakpoint;
  logic        undefined;
  modport source (output valid, output next_address, output dest_valid, output dest_index,
                  output dest_value, output nzcv, output branch_taken, output breakpoint,
                  output undefined, input ready);
  modport sink (input valid, input next_address, input dest_valid, input dest_index,
                input dest_value, input nzcv, input branch_taken, input breakpoint,
                input undefined, output ready);
endinterface

interface t16x_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/thumb16_integer_execute_unit.sv @@
// Top level: Thumb integer execute unit with register file, flags and result register.
//
//  channel     dir   modport  payload
//  inst_ch     in    sink     instruction[15:0]
//  result_ch   out   source   next_address, dest_valid/index/value, nzcv, branch_taken,
//                             breakpoint, undefined
//  cfg_ch      in    sink     index[7:0], data[31:0]
//
// One instruction per cycle sustained while the result channel is ready. An accepted
// instruction waits in the instruction register, then executes in a single pass of
// the decode/ALU/multiplier logic; architectural state and the result register update
// at that same edge, so the next instruction sees the new state.
// Reset (rst, synchronous) clears R0-R12 and flags, sets LR to all ones, SP to
// 0x20000000 and the fetch address to 0. A stalled result holds execution and the
// instruction register; accept continues while the result register can drain.
`default_nettype none
module thumb16_integer_execute_unit
  import t16x_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  t16x_inst_if.sink     inst_ch,
  t16x_result_if.source result_ch,
  t16x_cfg_if.sink      cfg_ch
);

  // instruction register
  logic        ins_valid;
  logic [15:0] ins;

  // architectural state
  gpr_file_t   gpr;
  logic [31:0] sp, lr, ia;
  logic [3:0]  nzcv;

  // result register
  logic         out_valid;
  exec_result_t out_q;

  arch_state_t  st;
  exec_result_t ex;
  logic         advance;

  assign st = '{gpr: gpr, sp: sp, lr: lr, ia: ia, nzcv: nzcv};

  t16x_exec u_exec (
    .ins (ins),
    .st  (st),
    .res (ex)
  );

  // execute when the result register is free or draining this cycle
  assign advance       = ins_valid && (!out_valid || result_ch.ready);
  assign inst_ch.ready = !ins_valid || advance;
  assign cfg_ch.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_valid <= 1'b0;
    end else if (inst_ch.ready) begin
      ins_valid <= inst_ch.valid;
    end
    if (inst_ch.ready && inst_ch.valid) ins <= inst_ch.instruction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr  <= '0;
      sp   <= SP_RESET;
      lr   <= LR_RESET;
      ia   <= FETCH_RESET;
      nzcv <= 4'd0;
    end else begin
      // commit: write back, flags and fetch address; undefined leaves state untouched
      if (advance && !ex.undefined) begin
        if (ex.dest_valid) begin
          if (ex.dest_index < 4'd13) gpr[ex.dest_index] <= ex.dest_value;
          else if (ex.dest_index == REG_SP) sp <= ex.dest_value;
          else if (ex.dest_index == REG_LR) lr <= ex.dest_value;
        end
        nzcv <= ex.nzcv;
        ia   <= ex.next_address;
      end
      // configuration writes load the live register at once
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_INIT_SP: begin
            sp <= cfg_ch.data;
          end
          CFG_INIT_FETCH: begin
            ia <= cfg_ch.data;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) out_q <= ex;
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.next_address = out_q.next_address;
  assign result_ch.dest_valid   = out_q.dest_valid;
  assign result_ch.dest_index   = out_q.dest_index;
  assign result_ch.dest_value   = out_q.dest_value;
  assign result_ch.nzcv         = out_q.nzcv;
  assign result_ch.branch_taken = out_q.branch_taken;
  assign result_ch.breakpoint   = out_q.breakpoint;
  assign result_ch.undefined    = out_q.undefined;

  // an undefined instruction never reports a write or a branch
  a_undef_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.undefined) |-> (!out_q.dest_valid && !out_q.branch_taken))
    else $error("undefined result reports a write or branch");

  // a committed instruction moves the fetch address to its reported next address
  a_ia_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && !ex.undefined && !cfg_ch.valid) |=> (ia == out_q.next_address))
    else $error("fetch address does not follow result");

  // a result is never produced without an instruction in the instruction register
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !ins_valid) |=> !out_valid)
    else $error("result appeared with no instruction");

  // a stack pointer configuration write loads the live stack pointer
  a_cfg_sp: assert property (@(posedge clk) disable iff (rst)
    (cfg_ch.valid && cfg_ch.index == CFG_INIT_SP) |=> (sp == $past(cfg_ch.data)))
    else $error("stack pointer not loaded by configuration");

endmodule
`default_nettype wire

@@ hdl/t16x_exec.sv @@
// Execute logic: decode one Thumb instruction against the architectural state.
`default_nettype none
module t16x_exec
  import t16x_pkg::*;
(
  input  wire logic [15:0]  ins,
  input  wire arch_state_t  st,
  output exec_result_t      res
);

  function automatic logic [31:0] rd_reg(input arch_state_t s, input logic [3:0] i);
    logic [31:0] v;
    if (i < 4'd13) v = s.gpr[i];
    else if (i == REG_SP) v = s.sp;
    else if (i == REG_LR) v = s.lr;
    else v = s.ia + 32'd4;
    return v;
  endfunction

  // add with carry in; returns {n,z,c,v,result}
  function automatic logic [35:0] add_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic cin);
    logic [32:0] s;
    logic ov;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    ov = (~(a[31] ^ b[31])) & (a[31] ^ s[31]);
    return {s[31], (s[31:0] == 32'd0), s[32], ov, s[31:0]};
  endfunction

  // shifts return {carry, result}; amount zero keeps carry
  function automatic logic [32:0] sh_l(input logic [31:0] x, input logic [7:0] n,
                                       input logic c);
    logic [32:0] t;
    t = {1'b0, x} << n;
    return (n == 8'd0) ? {c, x} : t;
  endfunction

  function automatic logic [32:0] sh_r(input logic [31:0] x, input logic [7:0] n,
                                       input logic c);
    logic [32:0] t;
    t = {x, 1'b0} >> n;
    return (n == 8'd0) ? {c, x} : {t[0], t[32:1]};
  endfunction

  function automatic logic [32:0] sh_a(input logic [31:0] x, input logic [7:0] n,
                                       input logic c);
    logic signed [32:0] t;
    t = $signed({x, 1'b0}) >>> n;
    return (n == 8'd0) ? {c, x} : {t[0], t[32:1]};
  endfunction

  function automatic logic [32:0] ro_r(input logic [31:0] x, input logic [7:0] n,
                                       input logic c);
    logic [63:0] t;
    t = {x, x} >> n[4:0];
    return (n == 8'd0) ? {c, x} : {t[31], t[31:0]};
  endfunction

  function automatic logic cond_ok(input logic [3:0] cd, input logic [3:0] f);
    logic r;
    case (cd[3:1])
      3'd0: r = f[2];
      3'd1: r = f[1];
      3'd2: r = f[3];
      3'd3: r = f[0];
      3'd4: r = f[1] & ~f[2];
      3'd5: r = (f[3] == f[0]);
      3'd6: r = ~f[2] & (f[3] == f[0]);
      default: r = 1'b1;
    endcase
    return cd[0] ? ~r : r;
  endfunction

  logic [4:0]  op5;
  logic [31:0] a, x3, m3, x8, xdn, m4, b3, imm8, prod;
  logic [3:0]  f, dn;
  logic        c;
  logic [35:0] ad;
  logic [32:0] sh;
  logic [31:0] off;

  assign op5  = ins[15:11];
  assign a    = st.ia;
  assign f    = st.nzcv;
  assign c    = st.nzcv[1];
  assign dn   = {ins[7], ins[2:0]};
  assign x3   = rd_reg(st, {1'b0, ins[5:3]});
  assign m3   = rd_reg(st, {1'b0, ins[8:6]});
  assign x8   = rd_reg(st, {1'b0, ins[10:8]});
  assign xdn  = rd_reg(st, dn);
  assign m4   = rd_reg(st, ins[6:3]);
  assign b3   = ins[10] ? {29'd0, ins[8:6]} : m3;
  assign imm8 = {24'd0, ins[7:0]};
  assign prod = rd_reg(st, {1'b0, ins[2:0]}) * x3;

  always_comb begin
    logic [31:0] xd;
    logic [7:0]  amt;
    xd  = rd_reg(st, {1'b0, ins[2:0]});
    amt = 8'd0;
    ad  = '0;
    sh  = '0;
    off = '0;
    res = '0;
    res.next_address = a + 32'd2;
    res.nzcv = f;
    if (ins == BKPT_ENC) begin
      res.breakpoint = 1'b1;
    end else if (op5 < 5'd3) begin
      amt = (ins[10:6] == 5'd0 && op5 != 5'd0) ? 8'd32 : {3'd0, ins[10:6]};
      case (op5[1:0])
        2'd0: sh = sh_l(x3, amt, c);
        2'd1: sh = sh_r(x3, amt, c);
        default: sh = sh_a(x3, amt, c);
      endcase
      res.dest_valid = 1'b1;
      res.dest_index = {1'b0, ins[2:0]};
      res.dest_value = sh[31:0];
      res.nzcv = {sh[31], sh[31:0] == 32'd0, sh[32], f[0]};
    end else if (op5 == 5'd3) begin
      ad = ins[9] ? add_f(x3, ~b3, 1'b1) : add_f(x3, b3, 1'b0);
      res.dest_valid = 1'b1;
      res.dest_index = {1'b0, ins[2:0]};
      res.dest_value = ad[31:0];
      res.nzcv = ad[35:32];
    end else if (op5 < 5'd8) begin
      case (op5[1:0])
        2'd0: begin
          res.dest_valid = 1'b1;
          res.dest_value = imm8;
          res.nzcv = {1'b0, imm8 == 32'd0, f[1:0]};
        end
        2'd1: begin
          ad = add_f(x8, ~imm8, 1'b1);
          res.nzcv = ad[35:32];
        end
        2'd2: begin
          ad = add_f(x8, imm8, 1'b0);
          res.dest_valid = 1'b1;
          res.dest_value = ad[31:0];
          res.nzcv = ad[35:32];
        end
        default: begin
          ad = add_f(x8, ~imm8, 1'b1);
          res.dest_valid = 1'b1;
          res.dest_value = ad[31:0];
          res.nzcv = ad[35:32];
        end
      endcase
      if (res.dest_valid) res.dest_index = {1'b0, ins[10:8]};
    end else if (ins[15:10] == 6'b010000) begin
      amt = x3[7:0];
      res.dest_valid = 1'b1;
      res.dest_index = {1'b0, ins[2:0]};
      sh = {c, 32'd0};
      case (ins[9:6])
        4'd0: sh = {c, xd & x3};
        4'd1: sh = {c, xd ^ x3};
        4'd2: sh = sh_l(xd, amt, c);
        4'd3: sh = sh_r(xd, amt, c);
        4'd4: sh = sh_a(xd, amt, c);
        4'd5: ad = add_f(xd, x3, c);
        4'd6: ad = add_f(xd, ~x3, c);
        4'd7: sh = ro_r(xd, amt, c);
        4'd8: sh = {c, xd & x3};
        4'd9: ad = add_f(32'd0, ~x3, 1'b1);
        4'd10: ad = add_f(xd, ~x3, 1'b1);
        4'd11: ad = add_f(xd, x3, 1'b0);
        4'd12: sh = {c, xd | x3};
        4'd13: sh = {c, prod};
        4'd14: sh = {c, xd & ~x3};
        default: sh = {c, ~x3};
      endcase
      if (ins[9:6] inside {4'd5, 4'd6, 4'd9, 4'd10, 4'd11}) begin
        res.dest_value = ad[31:0];
        res.nzcv = ad[35:32];
      end else begin
        res.dest_value = sh[31:0];
        res.nzcv = {sh[31], sh[31:0] == 32'd0, sh[32], f[0]};
      end
      if (ins[9:6] inside {4'd8, 4'd10, 4'd11}) begin
        res.dest_valid = 1'b0;
        res.dest_index = 4'd0;
        res.dest_value = 32'd0;
      end
    end else if (ins[15:10] == 6'b010001) begin
      case (ins[9:8])
        2'd3: begin
          if (ins[7]) begin
            res.undefined = 1'b1;
          end else begin
            res.next_address = {m4[31:1], 1'b0};
            res.branch_taken = 1'b1;
          end
        end
        2'd1: begin
          ad = add_f(xdn, ~m4, 1'b1);
          res.nzcv = ad[35:32];
        end
        default: begin
          res.dest_valid = 1'b1;
          res.dest_index = dn;
          res.dest_value = (ins[9:8] == 2'd0) ? xdn + m4 : m4;
          if (dn == REG_PC) begin
            res.dest_value[0] = 1'b0;
            res.next_address = {res.dest_value[31:1], 1'b0};
            res.branch_taken = 1'b1;
          end
        end
      endcase
    end else if (op5 == 5'h14) begin
      res.dest_valid = 1'b1;
      res.dest_index = {1'b0, ins[10:8]};
      res.dest_value = {a[31:2] + 30'd1, 2'b00} + {22'd0, ins[7:0], 2'b00};
    end else if (op5 == 5'h15) begin
      res.dest_valid = 1'b1;
      res.dest_index = {1'b0, ins[10:8]};
      res.dest_value = st.sp + {22'd0, ins[7:0], 2'b00};
    end else if (ins[15:8] == 8'hB0) begin
      res.dest_valid = 1'b1;
      res.dest_index = REG_SP;
      res.dest_value = ins[7] ? st.sp - {23'd0, ins[6:0], 2'b00}
                              : st.sp + {23'd0, ins[6:0], 2'b00};
    end else if (ins[15:12] == 4'hD && ins[11:8] < 4'd14) begin
      if (cond_ok(ins[11:8], f)) begin
        off = {{23{ins[7]}}, ins[7:0], 1'b0};
        res.next_address = a + 32'd4 + off;
        res.branch_taken = 1'b1;
      end
    end else if (op5 == 5'h1C) begin
      off = {{20{ins[10]}}, ins[10:0], 1'b0};
      res.next_address = a + 32'd4 + off;
      res.branch_taken = 1'b1;
    end else begin
      res.undefined = 1'b1;
    end
    if (res.undefined) begin
      res = '0;
      res.undefined = 1'b1;
      res.next_address = a;
      res.nzcv = f;
    end
  end
endmodule
`default_nettype wire

@@ sim/t16x_scoreboard.sv @@
// Scoreboard: predicts Thumb execute results and checks them in order.
`timescale 1ns / 100ps
package t16x_scoreboard_pkg;
  import t16x_pkg::*;

  class thumb_exec_scoreboard;
    logic [31:0] gpr [13];
    logic [31:0] sp, lr, ia, sp_init, fetch_init;
    logic [3:0]  flags;
    exec_result_t pending_q [$];
    int mismatches;
    int checked;

    function new();
      mismatches = 0;
      checked = 0;
      sp_init = SP_RESET;
      fetch_init = FETCH_RESET;
      reset_state();
    endfunction

    function void reset_state();
      foreach (gpr[i]) gpr[i] = '0;
      sp = sp_init;
      lr = LR_RESET;
      ia = fetch_init;
      flags = '0;
    endfunction

    function void write_cfg(logic [7:0] idx, logic [31:0] val);
      if (idx == CFG_INIT_SP) begin
        sp_init = val;
        sp = val;
      end else if (idx == CFG_INIT_FETCH) begin
        fetch_init = val;
        ia = val;
      end
    endfunction

    function logic [31:0] rd_reg(logic [3:0] i);
      if (i < 13) return gpr[i];
      if (i == REG_SP) return sp;
      if (i == REG_LR) return lr;
      return ia + 32'd4;
    endfunction

    function logic [3:0] nz(logic [3:0] f, logic [31:0] r);
      return {r[31], r == 0, f[1:0]};
    endfunction

    function logic [31:0] adder(logic [31:0] a, logic [31:0] b, logic cin,
                                output logic [3:0] f);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b} + cin;
      f = {s[31], s[31:0] == 0, s[32], (~(a[31] ^ b[31])) & (a[31] ^ s[31])};
      return s[31:0];
    endfunction

    function logic [31:0] shifter(int kind, logic [31:0] x, logic [31:0] n,
                                  inout logic [3:0] f);
      logic [31:0] r;
      if (n == 0) return x;
      case (kind)
        0: begin
          if (n < 32) begin
            f[1] = x[32 - n];
            r = x << n;
          end else begin
            f[1] = (n == 32) ? x[0] : 1'b0;
            r = '0;
          end
        end
        1: begin
          if (n < 32) begin
            f[1] = x[n - 1];
            r = x >> n;
          end else begin
            f[1] = (n == 32) ? x[31] : 1'b0;
            r = '0;
          end
        end
        2: begin
          if (n < 32) begin
            f[1] = x[n - 1];
            r = $unsigned($signed(x) >>> n);
          end else begin
            f[1] = x[31];
            r = {32{x[31]}};
          end
        end
        default: begin
          r = (x >> n[4:0]) | (x << (6'd32 - n[4:0]));
          if (n[4:0] == 0) r = x;
          f[1] = r[31];
        end
      endcase
      return r;
    endfunction

    function bit cond_ok(logic [3:0] c, logic [3:0] f);
      bit r;
      case (c[3:1])
        3'd0: r = f[2];
        3'd1: r = f[1];
        3'd2: r = f[3];
        3'd3: r = f[0];
        3'd4: r = f[1] && !f[2];
        3'd5: r = f[3] == f[0];
        3'd6: r = !f[2] && (f[3] == f[0]);
        default: r = 1;
      endcase
      return c[0] ? !r : r;
    endfunction

    // Execute one instruction against the shadow state and queue the result.
    function void note_instruction(logic [15:0] ins);
      exec_result_t e;
      logic [31:0] nxt, wv, x, m, b, off;
      logic [3:0] f, wi, dn, tf;
      logic [4:0] op5;
      bit wr, tk, bk, ud;
      nxt = ia + 2; f = flags; wi = 0; wv = 0;
      wr = 0; tk = 0; bk = 0; ud = 0; op5 = ins[15:11];
      if (ins == BKPT_ENC) begin
        bk = 1;
      end else if (op5 < 3) begin
        x = rd_reg({1'b0, ins[5:3]});
        if (op5 == 0) wv = shifter(0, x, ins[10:6], f);
        else wv = shifter(op5, x, ins[10:6] == 0 ? 32 : ins[10:6], f);
        f = nz(f, wv); wr = 1; wi = ins[2:0];
      end else if (op5 == 3) begin
        b = ins[10] ? ins[8:6] : rd_reg({1'b0, ins[8:6]});
        x = rd_reg({1'b0, ins[5:3]});
        wv = ins[9] ? adder(x, ~b, 1, f) : adder(x, b, 0, f);
        wr = 1; wi = ins[2:0];
      end else if (op5 < 8) begin
        wi = ins[10:8]; x = rd_reg(wi);
        case (op5[1:0])
          2'd0: begin wv = ins[7:0]; f = nz(f, wv); wr = 1; end
          2'd1: void'(adder(x, ~{24'd0, ins[7:0]}, 1, f));
          2'd2: begin wv = adder(x, ins[7:0], 0, f); wr = 1; end
          default: begin wv = adder(x, ~{24'd0, ins[7:0]}, 1, f); wr = 1; end
        endcase
      end else if (ins[15:10] == 6'h10) begin
        wi = ins[2:0]; x = rd_reg(wi); m = rd_reg({1'b0, ins[5:3]}); wr = 1;
        case (ins[9:6])
          4'd0: begin wv = x & m; f = nz(f, wv); end
          4'd1: begin wv = x ^ m; f = nz(f, wv); end
          4'd2: begin wv = shifter(0, x, m[7:0], f); f = nz(f, wv); end
          4'd3: begin wv = shifter(1, x, m[7:0], f); f = nz(f, wv); end
          4'd4: begin wv = shifter(2, x, m[7:0], f); f = nz(f, wv); end
          4'd5: wv = adder(x, m, flags[1], f);
          4'd6: wv = adder(x, ~m, flags[1], f);
          4'd7: begin wv = shifter(3, x, m[7:0], f); f = nz(f, wv); end
          4'd8: begin f = nz(f, x & m); wr = 0; end
          4'd9: wv = adder(0, ~m, 1, f);
          4'd10: begin void'(adder(x, ~m, 1, f)); wr = 0; end
          4'd11: begin void'(adder(x, m, 0, f)); wr = 0; end
          4'd12: begin wv = x | m; f = nz(f, wv); end
          4'd13: begin wv = x * m; f = nz(f, wv); end
          4'd14: begin wv = x & ~m; f = nz(f, wv); end
          default: begin wv = ~m; f = nz(f, wv); end
        endcase
      end else if (ins[15:10] == 6'h11) begin
        dn = {ins[7], ins[2:0]}; m = rd_reg(ins[6:3]);
        if (ins[9:8] == 3) begin
          if (ins[7]) ud = 1;
          else begin nxt = m & ~32'd1; tk = 1; end
        end else if (ins[9:8] == 1) begin
          void'(adder(rd_reg(dn), ~m, 1, f));
        end else begin
          wv = (ins[9:8] == 0) ? rd_reg(dn) + m : m;
          wr = 1; wi = dn;
          if (dn == REG_PC) begin wv[0] = 0; nxt = wv; tk = 1; end
        end
      end else if (op5 == 5'h14) begin
        wv = ((ia + 4) & ~32'd3) + {ins[7:0], 2'b00}; wr = 1; wi = ins[10:8];
      end else if (op5 == 5'h15) begin
        wv = sp + {ins[7:0], 2'b00}; wr = 1; wi = ins[10:8];
      end else if (ins[15:8] == 8'hB0) begin
        off = {ins[6:0], 2'b00};
        wv = ins[7] ? sp - off : sp + off; wr = 1; wi = REG_SP;
      end else if (ins[15:12] == 4'hD && ins[11:8] < 14) begin
        if (cond_ok(ins[11:8], f)) begin
          off = {{24{ins[7]}}, ins[7:0]};
          nxt = ia + 4 + (off << 1); tk = 1;
        end
      end else if (op5 == 5'h1C) begin
        off = {{21{ins[10]}}, ins[10:0]};
        nxt = ia + 4 + (off << 1); tk = 1;
      end else begin
        ud = 1;
      end
      if (ud) begin
        nxt = ia; f = flags; wr = 0; wi = 0; wv = 0; tk = 0;
      end else begin
        if (wr && wi < 13) gpr[wi] = wv;
        else if (wr && wi == REG_SP) sp = wv;
        else if (wr && wi == REG_LR) lr = wv;
        if (!wr) begin wi = 0; wv = 0; end
        flags = f;
        ia = nxt;
      end
      e.next_address = nxt; e.dest_valid = wr; e.dest_index = wi; e.dest_value = wv;
      e.nzcv = f; e.branch_taken = tk; e.breakpoint = bk; e.undefined = ud;
      pending_q.push_back(e);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", got.next_address, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.next_address !== want.next_address)
        report("next_address", got.next_address, want.next_address);
      if (got.dest_valid !== want.dest_valid)
        report("dest_valid", got.dest_valid, want.dest_valid);
      if (got.dest_index !== want.dest_index)
        report("dest_index", got.dest_index, want.dest_index);
      if (got.dest_value !== want.dest_value)
        report("dest_value", got.dest_value, want.dest_value);
      if (got.nzcv !== want.nzcv) report("nzcv", got.nzcv, want.nzcv);
      if (got.branch_taken !== want.branch_taken)
        report("branch_taken", got.branch_taken, want.branch_taken);
      if (got.breakpoint !== want.breakpoint)
        report("breakpoint", got.breakpoint, want.breakpoint);
      if (got.undefined !== want.undefined)
        report("undefined", got.undefined, want.undefined);
      checked++;
    endfunction
  endclass
endpackage

@@ sim/testbench.sv @@
// Testbench top: drives the Thumb execute unit and scores every result.
`timescale 1ns / 100ps
module testbench;
  import t16x_pkg::*;
  import t16x_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  t16x_inst_if   inst_ch ();
  t16x_result_if result_ch ();
  t16x_cfg_if    cfg_ch ();

  thumb16_integer_execute_unit u_top (
    .clk(clk), .rst(rst), .inst_ch(inst_ch), .result_ch(result_ch), .cfg_ch(cfg_ch)
  );

  thumb_exec_scoreboard exec_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int sent = 0;
  bit timed_out = 0;

  initial begin
    inst_ch.valid = 0;
    inst_ch.instruction = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    result_ch.ready = 0;
  end

  // Receiver: stall at random, check each transaction at the edge it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        exec_result_t r;
        r.next_address = result_ch.next_address;
        r.dest_valid = result_ch.dest_valid;
        r.dest_index = result_ch.dest_index;
        r.dest_value = result_ch.dest_value;
        r.nzcv = result_ch.nzcv;
        r.branch_taken = result_ch.branch_taken;
        r.breakpoint = result_ch.breakpoint;
        r.undefined = result_ch.undefined;
        exec_sb.check_result(r);
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if ((inst_ch.valid && inst_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Watchdog expired with %0d results outstanding", exec_sb.pending_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one instruction; hold valid high across back-to-back transactions.
  task automatic send_inst(logic [15:0] ins);
    while ($urandom_range(99) < send_idle_pct) begin
      inst_ch.valid <= 0;
      @(posedge clk);
    end
    inst_ch.valid <= 1;
    inst_ch.instruction <= ins;
    @(posedge clk);
    while (!inst_ch.ready) @(posedge clk);
    exec_sb.note_instruction(ins);
    sent++;
  endtask

  task automatic drain();
    inst_ch.valid <= 0;
    while (exec_sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register only with the pipe empty.
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    exec_sb.write_cfg(idx, val);
  endtask

  // Random instruction: mostly supported classes, with loads of operand setup.
  function automatic logic [15:0] pick_inst();
    int k;
    logic [15:0] r;
    k = $urandom_range(99);
    r = $urandom;
    if (k < 12) return {5'b00100, r[10:0]};                 // MOV imm seeds registers
    if (k < 22) return {3'b000, r[12:0]};                   // shifts / add-sub
    if (k < 26) return {3'b001, r[12:0]};
    if (k < 46) return {6'h10, r[9:0]};                     // register ALU
    if (k < 54) return {6'h11, r[9:8] == 3 ? {r[9:7], r[6:3], 3'b000} : r[9:0]};
    if (k < 60) return {4'hA, r[11:0]};                     // ADR / ADD SP
    if (k < 64) return {8'hB0, r[7:0]};
    if (k < 76) return {4'hD, r[11:0]};                     // conditional branch, SVC, udf
    if (k < 82) return {5'h1C, r[10:0]};
    if (k < 84) return BKPT_ENC;
    return r;                                               // anything at all
  endfunction

  initial begin
    logic [15:0] directed [$] = '{
      16'h20FF, 16'h2100, 16'h0FC8, 16'h07C8, 16'h0808, 16'h1008, 16'h1888, 16'h1FC8,
      16'h1A48, 16'h2900, 16'h38FF, 16'h4348, 16'h4248, 16'h41C8, 16'h4108, 16'h43C8,
      16'h4485, 16'h4500, 16'h46F0, 16'h4687, 16'h4770, 16'h47F0, 16'hDE00, 16'hD0FE,
      16'hE7FF};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i]) send_inst(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 38 : 0;
      case (phase)
        0: begin
          write_reg(CFG_INIT_SP, 32'h0000_0000);
          write_reg(CFG_INIT_FETCH, 32'hFFFF_FFFE);
        end
        1: begin
          write_reg(CFG_INIT_SP, 32'hFFFF_FFFF);
          write_reg(CFG_INIT_FETCH, $urandom);
        end
        default: begin
          write_reg(CFG_INIT_SP, $urandom);
          write_reg(CFG_INIT_FETCH, 32'h0000_0000);
        end
      endcase
      for (int n = 0; n < 260; n++) begin
        // Hold off once per phase until the pipe has emptied.
        if (n == 130) drain();
        send_inst(pick_inst());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d instructions, %0d results checked, across three SP/fetch settings",
             sent, exec_sb.checked);
    if (exec_sb.mismatches == 0 && exec_sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/t16x_pkg.sv
hdl/t16x_channels.sv
hdl/t16x_exec.sv
hdl/thumb16_integer_execute_unit.sv
sim/t16x_scoreboard.sv
sim/testbench.sv
